@@ rtl/core/esc_pkg.sv @@
`default_nettype none

package esc_pkg;

	// field widths
	localparam int SECS_W  = 32;
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DAYS_W  = 16;

	// 86400 = 2^7 * 675: shift off seven bits, then multiply by ceil(2^35 / 675)
	// and keep bits 35 and up; exact for every 25-bit dividend
	localparam int DIV_SHIFT = 7;
	localparam int DIVD_W    = SECS_W - DIV_SHIFT;
	localparam int RECIP_W   = 26;
	localparam int DIV_RECIP = 50903317;
	localparam int DIV_RSH   = 35;
	localparam int PROD_W    = DIVD_W + RECIP_W;

	// calendar constants
	localparam int FIRST_YEAR   = 1970;
	localparam int LAST_YEAR    = 2099;
	localparam int MONTHS       = 12;
	localparam int LIMIT_DAYS   = 47482;
	localparam int YEAR_DAYS    = 365;
	localparam int MONTH_FEB    = 2;

	// microcode
	localparam int STEP_W = 3;
	localparam int OP_W   = 3;
	localparam int COND_W = 3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [COND_W-1:0] cond_t;

	// datapath operations
	localparam op_t OP_LOAD  = 3'd0;
	localparam op_t OP_DIV   = 3'd1;
	localparam op_t OP_CHECK = 3'd2;
	localparam op_t OP_YEAR  = 3'd3;
	localparam op_t OP_MONTH = 3'd4;
	localparam op_t OP_EMIT  = 3'd5;

	// sequencer conditions
	localparam cond_t C_START  = 3'd0;
	localparam cond_t C_GE     = 3'd2;
	localparam cond_t C_ALWAYS = 3'd3;
	localparam cond_t C_NEXT   = 3'd4;

	// program addresses
	localparam step_t S_IDLE  = 3'd0;
	localparam step_t S_DIV   = 3'd1;
	localparam step_t S_CHECK = 3'd2;
	localparam step_t S_YEAR  = 3'd3;
	localparam step_t S_MONTH = 3'd4;
	localparam step_t S_EMIT  = 3'd5;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// control store: one word per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		unique case (step)
			S_IDLE:  w = '{op: OP_LOAD,  cond: C_START,  target: S_IDLE};
			S_DIV:   w = '{op: OP_DIV,   cond: C_NEXT,   target: S_CHECK};
			S_CHECK: w = '{op: OP_CHECK, cond: C_GE,     target: S_EMIT};
			S_YEAR:  w = '{op: OP_YEAR,  cond: C_GE,     target: S_YEAR};
			S_MONTH: w = '{op: OP_MONTH, cond: C_GE,     target: S_MONTH};
			S_EMIT:  w = '{op: OP_EMIT,  cond: C_ALWAYS, target: S_IDLE};
			default: w = '{op: OP_EMIT,  cond: C_ALWAYS, target: S_IDLE};
		endcase
		return w;
	endfunction

	// days in a common-year month, 1 is January
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo);
		logic [DAY_W-1:0] d;
		case (mo)
			4'd2:                       d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
			default:                    d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/epoch_seconds_to_calendar_date.sv @@
`default_nettype none

// Converts whole seconds since 1970-01-01 00:00 into year, month and day. Pulse start
// while busy is low; the result appears for exactly one cycle with done high, and the
// receiver cannot stall it, so capture it then. A small microcoded sequencer drives one
// shared compare/subtract datapath through these steps: accept, divide by 675 through a
// reciprocal multiply (after dropping 7 bits), range check, a year walk and a month walk
// that each stop at the first failed compare, and emit. Out-of-range inputs skip both
// walks and go from the range check straight to emit; for in-range inputs the year walk
// takes most of the time. Inputs at or after 2100-01-01 give 2099-12-31 with out_of_range
// set. busy drops in the cycle done is shown, so the next beat may be accepted in that same cycle.
module epoch_seconds_to_calendar_date (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [esc_pkg::SECS_W-1:0]    seconds_since_epoch,
	output      logic                          done,
	output      logic [esc_pkg::YEAR_W-1:0]    year_value,
	output      logic [esc_pkg::MONTH_W-1:0]   month_value,
	output      logic [esc_pkg::DAY_W-1:0]     day_of_month,
	output      logic                          out_of_range
);

	esc_pkg::step_t                    step_q;
	esc_pkg::step_t                    step_nxt;
	esc_pkg::ctrl_t                    ctrl;
	logic [esc_pkg::DIVD_W-1:0]        dq_q;
	logic [esc_pkg::DAYS_W-1:0]        days_q;
	logic [esc_pkg::YEAR_W-1:0]        year_q;
	logic [esc_pkg::MONTH_W-1:0]       mo_q;
	logic                              flag_q;
	logic                              done_q;
	logic [esc_pkg::YEAR_W-1:0]        year_out_q;
	logic [esc_pkg::MONTH_W-1:0]       mo_out_q;
	logic [esc_pkg::DAY_W-1:0]         day_out_q;
	logic                              flag_out_q;

	logic [esc_pkg::PROD_W-1:0]        div_prod;
	logic                              leap;
	logic [esc_pkg::DAYS_W-1:0]        cmp_a;
	logic [esc_pkg::DAYS_W-1:0]        cmp_b;
	logic                              ge;
	logic [esc_pkg::DAYS_W-1:0]        diff;

	// fetch the control word
	assign ctrl = esc_pkg::ucode(step_q);
	assign busy = (step_q != esc_pkg::S_IDLE);

	// divide by 675 as a multiply by its scaled reciprocal
	assign div_prod = esc_pkg::PROD_W'(dq_q) * esc_pkg::PROD_W'(esc_pkg::DIV_RECIP);

	// shared compare and subtract
	assign leap = (year_q[1:0] == 2'b00);
	always_comb begin
		cmp_a = days_q;
		cmp_b = esc_pkg::DAYS_W'(esc_pkg::YEAR_DAYS);
		case (ctrl.op)
			esc_pkg::OP_CHECK: begin
				cmp_a = dq_q[esc_pkg::DAYS_W-1:0];
				cmp_b = esc_pkg::DAYS_W'(esc_pkg::LIMIT_DAYS);
			end
			esc_pkg::OP_YEAR: begin
				cmp_b = esc_pkg::DAYS_W'(esc_pkg::YEAR_DAYS) + esc_pkg::DAYS_W'(leap);
			end
			esc_pkg::OP_MONTH: begin
				cmp_b = esc_pkg::DAYS_W'(esc_pkg::month_days(mo_q))
					+ esc_pkg::DAYS_W'(leap && (mo_q == esc_pkg::MONTH_W'(esc_pkg::MONTH_FEB)));
			end
			default: begin
				cmp_b = esc_pkg::DAYS_W'(esc_pkg::YEAR_DAYS);
			end
		endcase
	end
	assign ge   = (cmp_a >= cmp_b);
	assign diff = cmp_a - cmp_b;

	// sequencer next step
	always_comb begin
		step_nxt = esc_pkg::step_t'(step_q + 1'b1);
		unique case (ctrl.cond)
			esc_pkg::C_START:  step_nxt = start ? esc_pkg::step_t'(step_q + 1'b1) : ctrl.target;
			esc_pkg::C_GE:     if (ge) begin
				step_nxt = ctrl.target;
			end
			esc_pkg::C_ALWAYS: step_nxt = ctrl.target;
			esc_pkg::C_NEXT:   step_nxt = esc_pkg::step_t'(step_q + 1'b1);
			default:           step_nxt = esc_pkg::step_t'(step_q + 1'b1);
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= esc_pkg::S_IDLE;
			done_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			done_q <= (ctrl.op == esc_pkg::OP_EMIT);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (ctrl.op)
			esc_pkg::OP_LOAD: if (start) begin
				dq_q <= seconds_since_epoch[esc_pkg::SECS_W-1:esc_pkg::DIV_SHIFT];
			end
			esc_pkg::OP_DIV: begin
				dq_q <= esc_pkg::DIVD_W'(div_prod[esc_pkg::DIV_RSH +: esc_pkg::DAYS_W]);
			end
			esc_pkg::OP_CHECK: begin
				flag_q <= ge;
				if (ge) begin
					days_q <= esc_pkg::DAYS_W'(30);
					year_q <= esc_pkg::YEAR_W'(esc_pkg::LAST_YEAR);
					mo_q   <= esc_pkg::MONTH_W'(esc_pkg::MONTHS);
				end else begin
					days_q <= dq_q[esc_pkg::DAYS_W-1:0];
					year_q <= esc_pkg::YEAR_W'(esc_pkg::FIRST_YEAR);
					mo_q   <= esc_pkg::MONTH_W'(1);
				end
			end
			esc_pkg::OP_YEAR: if (ge) begin
				days_q <= diff;
				year_q <= esc_pkg::YEAR_W'(year_q + 1'b1);
			end
			esc_pkg::OP_MONTH: if (ge) begin
				days_q <= diff;
				mo_q   <= esc_pkg::MONTH_W'(mo_q + 1'b1);
			end
			esc_pkg::OP_EMIT: begin
				year_out_q <= year_q;
				mo_out_q   <= mo_q;
				day_out_q  <= esc_pkg::DAY_W'(days_q[esc_pkg::DAY_W-1:0] + 1'b1);
				flag_out_q <= flag_q;
			end
			default: begin
			end
		endcase
	end

	// result beat
	assign done         = done_q;
	assign year_value   = year_out_q;
	assign month_value  = mo_out_q;
	assign day_of_month = day_out_q;
	assign out_of_range = flag_out_q;

endmodule

`default_nettype wire

@@ rtl/core/esc_checker.sv @@
`default_nettype none

module esc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [esc_pkg::YEAR_W-1:0]    year_value,
	input wire logic [esc_pkg::MONTH_W-1:0]   month_value,
	input wire logic [esc_pkg::DAY_W-1:0]     day_of_month,
	input wire logic                          out_of_range
);

	// an accepted beat keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// busy ends exactly when a result is shown
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// a result is a single-cycle pulse after work
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result not preceded by busy");

	// calendar fields stay in range
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month_value >= 4'd1 && month_value <= 4'd12
			&& day_of_month >= 5'd1
			&& year_value >= 12'd1970 && year_value <= 12'd2099))
		else $error("result field out of range");

	// out of range holds the last supported date
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |->
			(year_value == 12'd2099 && month_value == 4'd12 && day_of_month == 5'd31))
		else $error("out-of-range result not clamped");

endmodule

bind epoch_seconds_to_calendar_date esc_checker u_esc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.year_value   (year_value),
	.month_value  (month_value),
	.day_of_month (day_of_month),
	.out_of_range (out_of_range)
);

`default_nettype wire
